// ----- sv/pic_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pic_pkg;

    localparam int NUM_SOURCES   = 256;
    localparam int NUM_CONTEXTS  = 4;
    localparam int PRIORITY_BITS = 3;

    // Scan geometry: eight sources per memory row.
    localparam int LANES     = 8;
    localparam int LANE_BITS = $clog2(LANES);
    localparam int ROWS      = NUM_SOURCES / LANES;
    localparam int ROW_BITS  = $clog2(ROWS);
    localparam int ID_BITS   = $clog2(NUM_SOURCES);
    localparam int CTX_BITS  = $clog2(NUM_CONTEXTS);
    localparam int WORDS     = (NUM_SOURCES + 31) / 32;

    localparam int ADDR_BITS = 26;

    localparam logic [ADDR_BITS-1:0] PRIO_END    = ADDR_BITS'(4 * NUM_SOURCES);
    localparam logic [ADDR_BITS-1:0] PEND_BASE   = ADDR_BITS'(32'h1000);
    localparam logic [ADDR_BITS-1:0] PEND_END    = ADDR_BITS'(32'h1000 + 4 * WORDS);
    localparam logic [ADDR_BITS-1:0] ENABLE_BASE = ADDR_BITS'(32'h2000);
    localparam logic [ADDR_BITS-1:0] ENABLE_END  =
        ADDR_BITS'(32'h2000 + 32'h80 * NUM_CONTEXTS);
    localparam logic [ADDR_BITS-1:0] CTX_BASE    = ADDR_BITS'(32'h200000);
    localparam logic [ADDR_BITS-1:0] CTX_END     =
        ADDR_BITS'(32'h200000 + 32'h1000 * NUM_CONTEXTS);
    localparam logic [11:0]          OFF_THRESH  = 12'h000;
    localparam logic [11:0]          OFF_CLAIM   = 12'h004;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_LEVEL = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIO,
        ST_SCAN,
        ST_DRAIN,
        ST_OUT
    } state_t;

    // Running arbitration result of one context.
    typedef struct packed {
        logic [PRIORITY_BITS-1:0] top;
        logic [ID_BITS-1:0]       pick;
    } best_t;

endpackage

`default_nettype wire

// ----- sv/pic_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface pic_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [25:0] address;
    logic [31:0] write_data;
    logic [7:0]  source_index;
    logic        source_level;

    modport source (output valid, action, address, write_data, source_index,
                    source_level, input ready);
    modport sink (input valid, action, address, write_data, source_index,
                  source_level, output ready);
endinterface

interface pic_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic [3:0]  interrupt_lines;
    logic        access_error;

    modport source (output valid, read_data, interrupt_lines, access_error,
                    input ready);
    modport sink (input valid, read_data, interrupt_lines, access_error,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/pic_arb.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One row of eight sources against the running best of every context.
module pic_arb (
    input  logic [pic_pkg::ROW_BITS-1:0]                        row,
    input  logic [pic_pkg::LANES*pic_pkg::PRIORITY_BITS-1:0]    prio,
    input  logic [pic_pkg::LANES-1:0]                           pend,
    input  logic [pic_pkg::NUM_CONTEXTS-1:0][pic_pkg::LANES-1:0] en,
    input  pic_pkg::best_t [pic_pkg::NUM_CONTEXTS-1:0]          best_in,
    output pic_pkg::best_t [pic_pkg::NUM_CONTEXTS-1:0]          best_out
);

    always_comb
    begin
        pic_pkg::best_t                   b;
        logic [pic_pkg::PRIORITY_BITS-1:0] p;
        for (int c = 0; c < pic_pkg::NUM_CONTEXTS; c++)
        begin
            b = best_in[c];
            // ascending id, strict compare keeps the lowest id on ties
            for (int l = 0; l < pic_pkg::LANES; l++)
            begin
                p = prio[l*pic_pkg::PRIORITY_BITS +: pic_pkg::PRIORITY_BITS];
                if (pend[l] && en[c][l] && (p > b.top))
                begin
                    b.top  = p;
                    b.pick = {row, pic_pkg::LANE_BITS'(l)};
                end
            end
            best_out[c] = b;
        end
    end

endmodule

`default_nettype wire

// ----- sv/platform_interrupt_controller_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Payload
// req      in   action, address, write_data, source_index, source_level
// rsp      out  read_data, interrupt_lines, access_error
//
// Every transfer on req is followed by a scan of the priority memory, one row of
// eight sources per cycle for all contexts at once, then a drain step for the last
// row. Priority accesses pass through a priority state first, claim reads run the
// scan twice. The result then waits until rsp takes it; req.ready returns the cycle
// after the rsp transfer.
// req.ready is high only while idle; a held result blocks the next transfer.
// Reset clears all state at once (per-row valid bits on the priority memory).

module platform_interrupt_controller_unit (
    input  logic         clk,
    input  logic         rst_n,
    pic_in_if.sink       req,
    pic_out_if.source    rsp
);

    localparam int NS  = pic_pkg::NUM_SOURCES;
    localparam int NC  = pic_pkg::NUM_CONTEXTS;
    localparam int PB  = pic_pkg::PRIORITY_BITS;
    localparam int LN  = pic_pkg::LANES;
    localparam int LB  = pic_pkg::LANE_BITS;
    localparam int RB  = pic_pkg::ROW_BITS;
    localparam int IB  = pic_pkg::ID_BITS;
    localparam int CB  = pic_pkg::CTX_BITS;
    localparam int RW  = LN * PB;

    pic_pkg::state_t state_reg, state_next;

    logic [RB-1:0]      scan_cnt_reg;
    logic               claim_reg;
    logic [CB-1:0]      claim_ctx_reg;
    logic               prio_wr_reg;
    logic [IB-1:0]      prio_id_reg;
    logic [PB-1:0]      prio_data_reg;
    logic [31:0]        rd_reg;
    logic               err_reg;
    logic [3:0]         lines_reg;

    logic [NS-1:0]          pending_reg;
    logic [NS-1:0]          insvc_reg;
    logic [NC-1:0][NS-1:0]  enable_reg;
    logic [NC-1:0][PB-1:0]  thresh_reg;

    logic [RW-1:0]      prio_mem [pic_pkg::ROWS];
    logic [pic_pkg::ROWS-1:0] row_valid_reg;
    logic [RW-1:0]      mem_rdata_reg;
    logic               mem_rvalid_reg;
    logic [RB-1:0]      mem_row_reg;
    logic               scan_vld_reg;

    pic_pkg::best_t [NC-1:0] best_reg, best_in, best_out;

    // ---------------- decode of the incoming item ----------------
    logic [25:0]  a;
    logic [31:0]  d;
    logic         aligned, is_prio, is_pend, is_en, is_ctx, is_thr, is_clm;
    logic         is_bus, is_wr, hit;
    logic [25:0]  en_off, ctx_off;
    logic [CB-1:0] en_ctx, ctx_sel;
    logic [2:0]   en_word;
    logic [2:0]   pend_word;
    logic [IB-1:0] prio_id;
    logic         accept;

    always_comb
    begin
        a        = req.address;
        d        = req.write_data;
        aligned  = (a[1:0] == 2'b00);
        is_prio  = aligned && (a < pic_pkg::PRIO_END);
        is_pend  = aligned && (a >= pic_pkg::PEND_BASE) && (a < pic_pkg::PEND_END);
        en_off   = a - pic_pkg::ENABLE_BASE;
        en_ctx   = en_off[7 +: CB];
        en_word  = en_off[4:2];
        is_en    = aligned && (a >= pic_pkg::ENABLE_BASE) && (a < pic_pkg::ENABLE_END)
                   && (en_off[6:5] == 2'b00);
        ctx_off  = a - pic_pkg::CTX_BASE;
        ctx_sel  = ctx_off[12 +: CB];
        is_ctx   = (a >= pic_pkg::CTX_BASE) && (a < pic_pkg::CTX_END);
        is_thr   = is_ctx && (ctx_off[11:0] == pic_pkg::OFF_THRESH);
        is_clm   = is_ctx && (ctx_off[11:0] == pic_pkg::OFF_CLAIM);
        is_bus   = (req.action == pic_pkg::ACT_READ) || (req.action == pic_pkg::ACT_WRITE);
        is_wr    = (req.action == pic_pkg::ACT_WRITE);
        hit      = is_prio || is_pend || is_en || is_thr || is_clm;
        pend_word = a[4:2];
        prio_id  = a[2 +: IB];
        accept   = req.valid && req.ready;
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        req.ready  = 1'b0;
        rsp.valid  = 1'b0;
        unique case (state_reg)
            pic_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    if (is_bus && is_prio)
                        state_next = pic_pkg::ST_PRIO;
                    else
                        state_next = pic_pkg::ST_SCAN;
                end
            end
            pic_pkg::ST_PRIO:
                state_next = pic_pkg::ST_SCAN;
            pic_pkg::ST_SCAN:
                if (scan_cnt_reg == RB'(pic_pkg::ROWS - 1))
                    state_next = pic_pkg::ST_DRAIN;
            pic_pkg::ST_DRAIN:
                state_next = claim_reg ? pic_pkg::ST_SCAN : pic_pkg::ST_OUT;
            pic_pkg::ST_OUT:
            begin
                rsp.valid = 1'b1;
                if (rsp.ready)
                    state_next = pic_pkg::ST_IDLE;
            end
            default:
                state_next = pic_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pic_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign rsp.read_data       = rd_reg;
    assign rsp.interrupt_lines = lines_reg;
    assign rsp.access_error    = err_reg;

    // ---------------- priority memory ----------------
    logic [RB-1:0] raddr;
    logic [RW-1:0] old_row, new_row;

    assign raddr   = (state_reg == pic_pkg::ST_IDLE) ? prio_id[IB-1 -: RB] : scan_cnt_reg;
    assign old_row = mem_rvalid_reg ? mem_rdata_reg : '0;

    always_comb
    begin
        new_row = old_row;
        new_row[prio_id_reg[LB-1:0]*PB +: PB] = prio_data_reg;
    end

    always_ff @(posedge clk)
    begin
        mem_rdata_reg <= prio_mem[raddr];
        mem_row_reg   <= raddr;
        if (state_reg == pic_pkg::ST_PRIO && prio_wr_reg && prio_id_reg != '0)
            prio_mem[prio_id_reg[IB-1 -: RB]] <= new_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg  <= '0;
            mem_rvalid_reg <= 1'b0;
            scan_vld_reg   <= 1'b0;
        end
        else
        begin
            mem_rvalid_reg <= row_valid_reg[raddr];
            scan_vld_reg   <= (state_reg == pic_pkg::ST_SCAN);
            if (state_reg == pic_pkg::ST_PRIO && prio_wr_reg && prio_id_reg != '0)
                row_valid_reg[prio_id_reg[IB-1 -: RB]] <= 1'b1;
        end
    end

    // ---------------- shared row arbiter ----------------
    logic [NC-1:0][LN-1:0] en_row;

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            en_row[c] = enable_reg[c][mem_row_reg*LN +: LN];
            if (mem_row_reg == '0)
            begin
                best_in[c].top  = thresh_reg[c];
                best_in[c].pick = '0;
            end
            else
                best_in[c] = best_reg[c];
        end
    end

    pic_arb u_arb (
        .row      (mem_row_reg),
        .prio     (old_row),
        .pend     (pending_reg[mem_row_reg*LN +: LN]),
        .en       (en_row),
        .best_in  (best_in),
        .best_out (best_out)
    );

    logic [IB-1:0] claim_id;
    assign claim_id = best_out[claim_ctx_reg].pick;

    always_ff @(posedge clk)
    begin
        if (scan_vld_reg)
            best_reg <= best_out;
    end

    // ---------------- architectural state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            insvc_reg     <= '0;
            enable_reg    <= '0;
            thresh_reg    <= '0;
            scan_cnt_reg  <= '0;
            claim_reg     <= 1'b0;
            claim_ctx_reg <= '0;
            prio_wr_reg   <= 1'b0;
            prio_id_reg   <= '0;
            prio_data_reg <= '0;
            rd_reg        <= '0;
            err_reg       <= 1'b0;
            lines_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                pic_pkg::ST_IDLE:
                begin
                    scan_cnt_reg <= '0;
                    if (accept)
                    begin
                        rd_reg        <= '0;
                        err_reg       <= is_bus && !hit;
                        claim_reg     <= 1'b0;
                        prio_wr_reg   <= is_wr;
                        prio_id_reg   <= prio_id;
                        prio_data_reg <= d[PB-1:0];
                        claim_ctx_reg <= ctx_sel;
                        if (req.action == pic_pkg::ACT_LEVEL)
                        begin
                            if (req.source_index != '0 && req.source_level
                                && !insvc_reg[req.source_index])
                                pending_reg[req.source_index] <= 1'b1;
                        end
                        else if (is_bus && is_pend)
                        begin
                            if (!is_wr)
                                rd_reg <= pending_reg[pend_word*32 +: 32];
                        end
                        else if (is_bus && is_en)
                        begin
                            if (is_wr)
                                enable_reg[en_ctx][en_word*32 +: 32] <=
                                    (en_word == '0) ? {d[31:1], 1'b0} : d;
                            else
                                rd_reg <= enable_reg[en_ctx][en_word*32 +: 32];
                        end
                        else if (is_bus && is_thr)
                        begin
                            if (is_wr)
                                thresh_reg[ctx_sel] <= d[PB-1:0];
                            else
                                rd_reg <= 32'(thresh_reg[ctx_sel]);
                        end
                        else if (is_bus && is_clm)
                        begin
                            if (is_wr)
                            begin
                                if (d[31:IB] == '0 && d != '0
                                    && enable_reg[ctx_sel][d[IB-1:0]])
                                    insvc_reg[d[IB-1:0]] <= 1'b0;
                            end
                            else
                                claim_reg <= 1'b1;
                        end
                    end
                end
                pic_pkg::ST_PRIO:
                begin
                    if (!prio_wr_reg)
                        rd_reg <= 32'(old_row[prio_id_reg[LB-1:0]*PB +: PB]);
                end
                pic_pkg::ST_SCAN:
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                pic_pkg::ST_DRAIN:
                begin
                    scan_cnt_reg <= '0;
                    if (claim_reg)
                    begin
                        // first pass picked the claim; second pass yields the lines
                        claim_reg <= 1'b0;
                        rd_reg    <= 32'(claim_id);
                        if (claim_id != '0)
                        begin
                            pending_reg[claim_id] <= 1'b0;
                            insvc_reg[claim_id]   <= 1'b1;
                        end
                    end
                    else
                    begin
                        for (int c = 0; c < 4; c++)
                            lines_reg[c] <= (c < NC) ? (best_out[c].pick != '0) : 1'b0;
                    end
                end
                pic_pkg::ST_OUT:
                    ;
                default:
                    ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- sv/pic_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pic_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] read_data,
    input logic        access_error
);

    // one item in flight: no new transfer while a result is offered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while result pending");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready right after transfer");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> !out_valid)
        else $error("result repeated");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && access_error) |-> (read_data == 32'd0))
        else $error("error with nonzero data");

endmodule

bind platform_interrupt_controller_unit pic_chk u_pic_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (req.valid),
    .in_ready     (req.ready),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .read_data    (rsp.read_data),
    .access_error (rsp.access_error)
);

`default_nettype wire

// ----- sim/pic_checker.sv -----
`timescale 1ns / 1ps

module pic_checker (
    input  logic   clk,
    input  logic   rst_n,
    pic_in_if      req,
    pic_out_if     rsp,
    output int     fail_count,
    output int     pending_count,
    output int     claims_seen
);

    localparam int NS = pic_pkg::NUM_SOURCES;
    localparam int NC = pic_pkg::NUM_CONTEXTS;
    localparam int PB = pic_pkg::PRIORITY_BITS;

    typedef struct packed {
        logic [31:0] read_data;
        logic [3:0]  lines;
        logic        err;
    } reply_t;

    logic [PB-1:0] prio_mem [NS];
    logic [NS-1:0] pend_vec;
    logic [NS-1:0] serv_vec;
    logic [NS-1:0] en_vec [NC];
    logic [PB-1:0] thresh [NC];
    reply_t        replies_due [$];

    function automatic int pick_source(int c);
        int top;
        int pick;
        top  = thresh[c];
        pick = 0;
        for (int id = 1; id < NS; id++)
            if (pend_vec[id] && en_vec[c][id] && int'(prio_mem[id]) > top)
            begin
                top  = prio_mem[id];
                pick = id;
            end
        return pick;
    endfunction

    function automatic logic [31:0] pack_bits(logic [NS-1:0] v, int w);
        logic [31:0] r;
        r = '0;
        for (int b = 0; b < 32; b++)
            if (w * 32 + b != 0 && w * 32 + b < NS)
                r[b] = v[w * 32 + b];
        return r;
    endfunction

    // Applies one bus access; returns 0 when the offset hits no register.
    function automatic bit bus_op(bit wr, logic [25:0] a, logic [31:0] d,
                                  output logic [31:0] rd);
        int c;
        int w;
        int off;
        int id;
        rd = '0;
        if (a[1:0] != 0)
            return 0;
        if (a < pic_pkg::PRIO_END)
        begin
            id = a / 4;
            if (id == 0)
                return 1;
            if (wr)
                prio_mem[id] = d[PB-1:0];
            else
                rd = 32'(prio_mem[id]);
            return 1;
        end
        if (a >= pic_pkg::PEND_BASE && a < pic_pkg::PEND_END)
        begin
            if (!wr)
                rd = pack_bits(pend_vec, (a - pic_pkg::PEND_BASE) / 4);
            return 1;
        end
        if (a >= pic_pkg::ENABLE_BASE && a < pic_pkg::ENABLE_END)
        begin
            c = (a - pic_pkg::ENABLE_BASE) / 'h80;
            w = ((a - pic_pkg::ENABLE_BASE) % 'h80) / 4;
            if (w >= pic_pkg::WORDS)
                return 0;
            if (!wr)
                rd = pack_bits(en_vec[c], w);
            else
                for (int b = 0; b < 32; b++)
                    if (w * 32 + b != 0 && w * 32 + b < NS)
                        en_vec[c][w * 32 + b] = d[b];
            return 1;
        end
        if (a >= pic_pkg::CTX_BASE && a < pic_pkg::CTX_END)
        begin
            c   = (a - pic_pkg::CTX_BASE) / 'h1000;
            off = (a - pic_pkg::CTX_BASE) % 'h1000;
            if (off == pic_pkg::OFF_THRESH)
            begin
                if (wr)
                    thresh[c] = d[PB-1:0];
                else
                    rd = 32'(thresh[c]);
                return 1;
            end
            if (off == pic_pkg::OFF_CLAIM)
            begin
                if (wr)
                begin
                    if (d != 0 && d < NS && en_vec[c][d])
                        serv_vec[d] = 1'b0;
                end
                else
                begin
                    id = pick_source(c);
                    if (id != 0)
                    begin
                        pend_vec[id] = 1'b0;
                        serv_vec[id] = 1'b1;
                        claims_seen++;
                    end
                    rd = id;
                end
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic reply_t predict_reply(logic [1:0] act, logic [25:0] a,
                                             logic [31:0] d, logic [7:0] src,
                                             logic lvl);
        reply_t r;
        r = '0;
        if (act == pic_pkg::ACT_READ || act == pic_pkg::ACT_WRITE)
            r.err = !bus_op(act == pic_pkg::ACT_WRITE, a, d, r.read_data);
        else if (act == pic_pkg::ACT_LEVEL && src != 0 && lvl && !serv_vec[src])
            pend_vec[src] = 1'b1;
        for (int c = 0; c < NC && c < 4; c++)
            r.lines[c] = pick_source(c) != 0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reply_t exp_r;
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
                prio_mem[i] = '0;
            pend_vec = '0;
            serv_vec = '0;
            for (int c = 0; c < NC; c++)
            begin
                en_vec[c] = '0;
                thresh[c] = '0;
            end
            replies_due.delete();
            fail_count    = 0;
            claims_seen   = 0;
            pending_count = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (replies_due.size() == 0)
                begin
                    $display("%t: unexpected result rd=%h lines=%h err=%b", $time,
                             rsp.read_data, rsp.interrupt_lines, rsp.access_error);
                    fail_count++;
                end
                else
                begin
                    exp_r = replies_due.pop_front();
                    if (rsp.read_data !== exp_r.read_data)
                    begin
                        $display("%t: read_data expected %h actual %h", $time,
                                 exp_r.read_data, rsp.read_data);
                        fail_count++;
                    end
                    if (rsp.interrupt_lines !== exp_r.lines)
                    begin
                        $display("%t: interrupt_lines expected %h actual %h", $time,
                                 exp_r.lines, rsp.interrupt_lines);
                        fail_count++;
                    end
                    if (rsp.access_error !== exp_r.err)
                    begin
                        $display("%t: access_error expected %b actual %b", $time,
                                 exp_r.err, rsp.access_error);
                        fail_count++;
                    end
                end
            end
            if (req.valid && req.ready)
                replies_due.push_back(predict_reply(req.action, req.address,
                    req.write_data, req.source_index, req.source_level));
            pending_count = replies_due.size();
        end
    end

endmodule

// ----- sim/platform_interrupt_controller_unit_tb.sv -----
`timescale 1ns / 1ps

module platform_interrupt_controller_unit_tb;

    localparam int NS = pic_pkg::NUM_SOURCES;
    localparam int NC = pic_pkg::NUM_CONTEXTS;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   claims_seen;
    int   sent;
    bit   rx_hold;
    bit   stim_done;

    pic_in_if  req ();
    pic_out_if rsp ();

    platform_interrupt_controller_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    pic_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .claims_seen   (claims_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("platform_interrupt_controller_unit_tb: FAIL");
        $finish;
    end

    // One transfer, after a random gap unless gap is cleared.
    task automatic send(logic [1:0] act, logic [25:0] a, logic [31:0] d,
                        logic [7:0] src, logic lvl, bit gap = 1);
        int n;
        n = gap ? $urandom_range(0, 18) : 0;
        repeat (n) @(posedge clk);
        req.valid        <= 1'b1;
        req.action       <= act;
        req.address      <= a;
        req.write_data   <= d;
        req.source_index <= src;
        req.source_level <= lvl;
        do @(posedge clk); while (!req.ready);
        req.valid <= 1'b0;
        sent++;
    endtask

    task automatic wait_drain();
        while (pending_count != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic logic [25:0] ctx_reg(int c, bit claim);
        return pic_pkg::CTX_BASE + 26'(c * 'h1000)
               + (claim ? 26'(pic_pkg::OFF_CLAIM) : 26'd0);
    endfunction

    function automatic logic [25:0] rand_addr();
        case ($urandom_range(0, 7))
            0, 1: return 26'($urandom_range(0, NS - 1) * 4);
            2:    return pic_pkg::PEND_BASE + 26'($urandom_range(0, 8) * 4);
            3:    return pic_pkg::ENABLE_BASE + 26'($urandom_range(0, 'h200 - 4) & ~3);
            4:    return ctx_reg($urandom_range(0, NC), 0);
            5:    return 26'($urandom) & 26'h3FFFFFF;
            default: return ctx_reg($urandom_range(0, NC - 1), 1);
        endcase
    endfunction

    // Receiver: random stall per result, one long hold-off on request.
    initial
    begin
        int n;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold)
            begin
                rsp.ready <= 1'b0;
                repeat (400) @(posedge clk);
                rx_hold = 0;
            end
            n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
            if (n > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do @(posedge clk); while (!rsp.valid);
        end
    end

    initial
    begin
        logic [1:0] act;
        int c;
        req.valid        = 1'b0;
        req.action       = pic_pkg::ACT_READ;
        req.address      = '0;
        req.write_data   = '0;
        req.source_index = '0;
        req.source_level = 1'b0;
        rst_n            = 1'b0;
        sent             = 0;
        rx_hold          = 0;
        stim_done        = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, reserved source, claim/complete, errors.
        send(pic_pkg::ACT_WRITE, 26'h4, 32'hFFFF_FFFF, 0, 0);
        send(pic_pkg::ACT_WRITE, 26'h3FC, 32'h5, 0, 0);
        send(pic_pkg::ACT_WRITE, 26'h0, 32'h7, 0, 0);
        send(pic_pkg::ACT_WRITE, pic_pkg::ENABLE_BASE, 32'hFFFF_FFFF, 0, 0);
        send(pic_pkg::ACT_WRITE, pic_pkg::ENABLE_BASE + 26'h1C, 32'h8000_0000, 0, 0);
        send(pic_pkg::ACT_LEVEL, 0, 0, 8'd1, 1);
        send(pic_pkg::ACT_LEVEL, 0, 0, 8'd0, 1);
        send(pic_pkg::ACT_LEVEL, 0, 0, 8'd255, 1);
        send(pic_pkg::ACT_LEVEL, 0, 0, 8'd2, 0);
        send(pic_pkg::ACT_READ, pic_pkg::PEND_BASE, 0, 0, 0);
        send(pic_pkg::ACT_WRITE, pic_pkg::PEND_BASE, 32'hFFFF_FFFF, 0, 0);
        send(pic_pkg::ACT_READ, ctx_reg(0, 1), 0, 0, 0);
        send(pic_pkg::ACT_LEVEL, 0, 0, 8'd1, 1);
        send(pic_pkg::ACT_READ, ctx_reg(0, 1), 0, 0, 0);
        send(pic_pkg::ACT_WRITE, ctx_reg(0, 1), 32'd0, 0, 0);
        send(pic_pkg::ACT_WRITE, ctx_reg(0, 1), 32'd1, 0, 0);
        send(pic_pkg::ACT_WRITE, ctx_reg(3, 0), 32'hFFFF_FFFF, 0, 0);
        send(pic_pkg::ACT_READ, ctx_reg(3, 0), 0, 0, 0);
        send(pic_pkg::ACT_READ, ctx_reg(3, 1), 0, 0, 0);
        send(pic_pkg::ACT_READ, 26'h3FF_FFFF, 0, 0, 0);
        send(pic_pkg::ACT_WRITE, 26'h2, 32'h1, 0, 0);
        send(pic_pkg::ACT_READ, pic_pkg::ENABLE_BASE + 26'h20, 0, 0, 0);
        send(pic_pkg::ACT_READ, ctx_reg(0, 0) + 26'h8, 0, 0, 0);
        send(pic_pkg::ACT_NONE, 26'h3FF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1);

        // Long receiver hold-off while requests keep coming.
        rx_hold = 1;
        repeat (6) send(pic_pkg::ACT_LEVEL, 0, 0, 8'($urandom_range(1, 255)), 1, 0);
        // Sender pause until all results are in.
        wait_drain();

        for (int i = 0; i < 600; i++)
        begin
            c = $urandom_range(0, NC - 1);
            case ($urandom_range(0, 9))
                0, 1, 2: send(pic_pkg::ACT_LEVEL, 0, 0, 8'($urandom), 1'($urandom));
                3: send(pic_pkg::ACT_WRITE, 26'($urandom_range(0, NS - 1) * 4),
                        $urandom, 0, 0);
                4: send(pic_pkg::ACT_WRITE,
                        pic_pkg::ENABLE_BASE + 26'(c * 'h80 + $urandom_range(0, 7) * 4),
                        $urandom, 0, 0);
                5: send(pic_pkg::ACT_WRITE, ctx_reg(c, 0), 32'($urandom_range(0, 3)), 0, 0);
                6: send(pic_pkg::ACT_READ, ctx_reg(c, 1), 0, 0, 0);
                7: send(pic_pkg::ACT_WRITE, ctx_reg(c, 1), 32'($urandom_range(0, 300)), 0, 0);
                default:
                begin
                    act = 2'($urandom_range(0, 3));
                    send(act, rand_addr(), $urandom, 8'($urandom), 1'($urandom));
                end
            endcase
            if (i == 300)
                wait_drain();
        end

        stim_done = 1;
        wait_drain();
        $display("%0d transfers sent, %0d sources claimed", sent, claims_seen);
        $display("covered priority, pending, enable, threshold, claim/complete and errors");
        if (fail_count == 0)
            $display("platform_interrupt_controller_unit_tb: PASS");
        else
            $display("platform_interrupt_controller_unit_tb: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/pic_pkg.sv
sv/pic_if.sv
sv/pic_arb.sv
sv/platform_interrupt_controller_unit.sv
sv/pic_chk.sv
sim/pic_checker.sv
sim/platform_interrupt_controller_unit_tb.sv
